@@ sv/bmprle_pkg.sv @@
package bmprle_pkg;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_CODE,
    PH_DX,
    PH_DY,
    PH_DATA,
    PH_PAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SPAN,
    KIND_DONE,
    KIND_TRUNC
  } kind_e;

  // escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // configuration register indices
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic       MODE_RLE8  = 1'b0;
  localparam logic [12:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    logic        mode;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  length;
    logic [7:0]  value;
    logic        last;
  } res_t;

endpackage

@@ sv/bmp_rle_decoder.sv @@
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o  | stream_byte_i, final_byte_i
// out     | output    | out_valid_o / out_stall_i| result_kind_o, span_*_o, last_of_run_o
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte per cycle unless a stall or a held result blocks the parser: a byte
// is registered in the input register, then the parser updates its state and
// loads the output register in the same cycle. For a span plus a status, the
// status waits in a holding register, which blocks the parser until it moves on.
// Reset clears the parser and sets mode RLE8, width and height 4096.
// Output stall holds the result registers; input stall follows from them.
module bmp_rle_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [11:0] span_column_o,
  output logic [11:0] span_row_o,
  output logic [7:0]  span_length_o,
  output logic [7:0]  span_value_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  bmprle_pkg::cfg_t cfg_q;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;

  logic             out_vld_q, nxt_vld_q;
  bmprle_pkg::res_t out_q, nxt_q;

  bmprle_pkg::res_t res0, res1;
  logic [1:0]       res_vld;

  logic accept, pop, proc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= bmprle_pkg::MODE_RLE8;
      cfg_q.width  <= bmprle_pkg::DIM_RESET;
      cfg_q.height <= bmprle_pkg::DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bmprle_pkg::CFG_MODE:   cfg_q.mode   <= cfg_data_i[0];
        bmprle_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        bmprle_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pop        = out_vld_q && !out_stall_i;
  assign proc       = in_vld_q && !nxt_vld_q && (!out_vld_q || pop);
  assign in_stall_o = in_vld_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept || (in_vld_q && !proc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= stream_byte_i;
      in_fin_q  <= final_byte_i;
    end
  end

  bmprle_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (proc),
    .byte_i   (in_byte_q),
    .fin_i    (in_fin_q),
    .cfg_i    (cfg_q),
    .res0_o   (res0),
    .res1_o   (res1),
    .res_vld_o(res_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      nxt_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= res_vld[0];
      nxt_vld_q <= res_vld[1];
    end else if (pop) begin
      out_vld_q <= nxt_vld_q;
      nxt_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res0;
      nxt_q <= res1;
    end else if (pop) begin
      out_q <= nxt_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_kind_o = out_q.kind;
  assign span_column_o = out_q.column;
  assign span_row_o    = out_q.row;
  assign span_length_o = out_q.length;
  assign span_value_o  = out_q.value;
  assign last_of_run_o = out_q.last;

`ifndef SYNTH
  a_nxt_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nxt_vld_q |-> out_vld_q)
    else $error("holding register full with output register empty");

  a_pop_moves_nxt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && nxt_vld_q && !proc) |=> out_vld_q)
    else $error("second result lost on pop");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.kind != bmprle_pkg::KIND_SPAN)) |-> out_q.last)
    else $error("status result not flagged last");

  a_pair_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && nxt_vld_q) |-> !out_q.last)
    else $error("first of a result pair flagged last");
`endif

endmodule

@@ sv/bmprle_core.sv @@
module bmprle_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              fin_i,
  input  bmprle_pkg::cfg_t  cfg_i,
  output bmprle_pkg::res_t  res0_o,
  output bmprle_pkg::res_t  res1_o,
  output logic [1:0]        res_vld_o
);

  localparam int WCap = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int RCap = (MAX_HEIGHT < 8191) ? MAX_HEIGHT : 8191;
  localparam int CW   = $clog2(WCap + 1);
  localparam int RW   = $clog2(RCap + 1);

  bmprle_pkg::phase_e phase_q, phase_d;
  logic [7:0]    held_q, held_d;
  logic [7:0]    dbl_q, dbl_d;
  logic [7:0]    nl_q, nl_d;
  logic          pad_q, pad_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    dx_q, dx_d;
  logic          stopped_q, stopped_d;

  logic [CW-1:0] w;
  logic [RW-1:0] h;

  always_comb begin
    w = (cfg_i.width > 13'(WCap)) ? CW'(WCap) : CW'(cfg_i.width);
    h = (cfg_i.height > 13'(RCap)) ? RW'(RCap) : RW'(cfg_i.height);
  end

  always_comb begin
    logic        stop;
    logic        go_count;
    logic        span_en;
    logic [7:0]  cnt;
    logic [8:0]  half;
    logic [13:0] csum;
    logic [13:0] rsum;
    logic [13:0] avail;
    logic [13:0] len14;
    logic [7:0]  dbl_nxt;
    logic        emit;
    logic        trunc;
    bmprle_pkg::res_t sp;
    bmprle_pkg::res_t st;

    phase_d   = phase_q;
    held_d    = held_q;
    dbl_d     = dbl_q;
    nl_d      = nl_q;
    pad_d     = pad_q;
    col_d     = col_q;
    row_d     = row_q;
    dx_d      = dx_q;
    go_count  = 1'b0;
    span_en   = 1'b0;
    cnt       = '0;
    half      = (9'(byte_i) + 9'd1) >> 1;
    csum      = 14'(col_q) + 14'(dx_q);
    rsum      = '0;
    dbl_nxt   = (dbl_q != '0) ? dbl_q - 8'd1 : '0;

    stop      = stopped_q | ((phase_q == bmprle_pkg::PH_COUNT) && (row_q >= h));
    stopped_d = stop;

    if (!stop) begin
      case (phase_q)
        bmprle_pkg::PH_COUNT: begin
          held_d  = byte_i;
          phase_d = bmprle_pkg::PH_CODE;
        end
        bmprle_pkg::PH_CODE: begin
          if (held_q != '0) begin
            span_en  = 1'b1;
            cnt      = held_q;
            go_count = 1'b1;
          end else if (byte_i == bmprle_pkg::ESC_EOL) begin
            rsum     = 14'(row_q) + 14'd1;
            col_d    = '0;
            row_d    = (rsum < 14'(h)) ? RW'(rsum) : h;
            go_count = 1'b1;
          end else if (byte_i == bmprle_pkg::ESC_EOB) begin
            stopped_d = 1'b1;
            phase_d   = bmprle_pkg::PH_COUNT;
          end else if (byte_i == bmprle_pkg::ESC_DELTA) begin
            phase_d = bmprle_pkg::PH_DX;
          end else if (cfg_i.mode == bmprle_pkg::MODE_RLE8) begin
            dbl_d   = byte_i;
            nl_d    = '0;
            pad_d   = byte_i[0];
            phase_d = bmprle_pkg::PH_DATA;
          end else begin
            nl_d    = byte_i;
            dbl_d   = half[7:0];
            pad_d   = half[0];
            phase_d = bmprle_pkg::PH_DATA;
          end
        end
        bmprle_pkg::PH_DX: begin
          dx_d    = byte_i;
          phase_d = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          rsum     = 14'(row_q) + 14'(byte_i);
          col_d    = (csum < 14'(w)) ? CW'(csum) : w;
          row_d    = (rsum < 14'(h)) ? RW'(rsum) : h;
          go_count = 1'b1;
        end
        bmprle_pkg::PH_DATA: begin
          span_en = 1'b1;
          if (cfg_i.mode == bmprle_pkg::MODE_RLE8) begin
            cnt = 8'd1;
          end else begin
            cnt  = (nl_q >= 8'd2) ? 8'd2 : nl_q;
            nl_d = nl_q - cnt;
          end
          dbl_d = dbl_nxt;
          if (dbl_nxt == '0) begin
            if (pad_q) begin
              phase_d = bmprle_pkg::PH_PAD;
            end else begin
              go_count = 1'b1;
            end
          end
        end
        bmprle_pkg::PH_PAD: begin
          pad_d    = 1'b0;
          go_count = 1'b1;
        end
        default: begin
          go_count = 1'b1;
        end
      endcase
    end

    if (go_count) begin
      phase_d = bmprle_pkg::PH_COUNT;
      if (row_d >= h) begin
        stopped_d = 1'b1;
      end
    end

    // span clipped at the image width
    avail = (col_q < w) ? (14'(w) - 14'(col_q)) : '0;
    len14 = (14'(cnt) < avail) ? 14'(cnt) : avail;
    emit  = span_en && (len14 != '0) && (row_q < h);
    if (emit) begin
      col_d = CW'(14'(col_q) + len14);
    end

    trunc = !stopped_d && ((phase_d == bmprle_pkg::PH_DX) ||
                           (phase_d == bmprle_pkg::PH_DY) ||
                           (phase_d == bmprle_pkg::PH_DATA));

    sp.kind   = bmprle_pkg::KIND_SPAN;
    sp.column = 12'(col_q);
    sp.row    = 12'(row_q);
    sp.length = len14[7:0];
    sp.value  = byte_i;
    sp.last   = !fin_i;

    st.kind   = trunc ? bmprle_pkg::KIND_TRUNC : bmprle_pkg::KIND_DONE;
    st.column = '0;
    st.row    = '0;
    st.length = '0;
    st.value  = '0;
    st.last   = 1'b1;

    res0_o    = emit ? sp : st;
    res1_o    = st;
    res_vld_o = {emit & fin_i, emit | fin_i};

    if (fin_i) begin
      phase_d   = bmprle_pkg::PH_COUNT;
      held_d    = '0;
      dbl_d     = '0;
      nl_d      = '0;
      pad_d     = 1'b0;
      col_d     = '0;
      row_d     = '0;
      dx_d      = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bmprle_pkg::PH_COUNT;
      held_q    <= '0;
      dbl_q     <= '0;
      nl_q      <= '0;
      pad_q     <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      dx_q      <= '0;
      stopped_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      dbl_q     <= dbl_d;
      nl_q      <= nl_d;
      pad_q     <= pad_d;
      col_q     <= col_d;
      row_q     <= row_d;
      dx_q      <= dx_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

@@ tb/tb_bmp_rle_decoder.sv @@
`timescale 1ns / 1ps

module tb_bmp_rle_decoder;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam logic MODE_RLE4 = 1'b1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_SEGS = 12;
  localparam int SEG_BYTES = 100;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } stream_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte = '0;
  logic        final_flag = 1'b0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind_o;
  logic [11:0] span_column_o;
  logic [11:0] span_row_o;
  logic [7:0]  span_length_o;
  logic [7:0]  span_value_o;
  logic        last_of_run_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  bmp_rle_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte),
    .final_byte_i  (final_flag),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .result_kind_o (result_kind_o),
    .span_column_o (span_column_o),
    .span_row_o    (span_row_o),
    .span_length_o (span_length_o),
    .span_value_o  (span_value_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // decoder mirror: configuration and parse state
  logic               cfg_mode = bmprle_pkg::MODE_RLE8;
  int                 cfg_w = 4096;
  int                 cfg_h = 4096;
  bmprle_pkg::phase_e ph = bmprle_pkg::PH_COUNT;
  int                 held_cnt, bytes_left, nib_left, delta_col, cur_col, cur_row;
  logic               pad_due, halted;

  stream_item_t     byte_q[$];
  stream_item_t     next_item;
  bmprle_pkg::res_t step_out[$];
  bmprle_pkg::res_t predicted_spans[$];

  logic in_taken = 1'b0;
  int   send_gap_pct = 38;
  int   recv_stall_pct = 77;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   bytes_in = 0;
  int   spans_seen = 0;
  int   status_seen = 0;
  int   configs_used = 1;

  logic        seg_mode[NUM_SEGS] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
  int          seg_w[NUM_SEGS] = '{16, 16, 4096, 1, 0, 40, 8191, 4096, 300, 7, 64, 64};
  int          seg_h[NUM_SEGS] = '{8, 8, 4096, 3, 5, 0, 8191, 1, 20, 4096, 32, 32};

  function automatic void clear_parse();
    ph = bmprle_pkg::PH_COUNT;
    held_cnt = 0;
    bytes_left = 0;
    nib_left = 0;
    pad_due = 1'b0;
    cur_col = 0;
    cur_row = 0;
    delta_col = 0;
    halted = 1'b0;
  endfunction

  function automatic void back_to_count(int h);
    ph = bmprle_pkg::PH_COUNT;
    if (cur_row >= h) halted = 1'b1;
  endfunction

  function automatic void put_span(int cnt, logic [7:0] val, int w, int h);
    int               avail, len;
    bmprle_pkg::res_t r;
    avail = (cur_col < w) ? w - cur_col : 0;
    len = (cnt < avail) ? cnt : avail;
    if (len == 0 || cur_row >= h) return;
    r = '0;
    r.kind = bmprle_pkg::KIND_SPAN;
    r.column = cur_col[11:0];
    r.row = cur_row[11:0];
    r.length = len[7:0];
    r.value = val;
    step_out.push_back(r);
    cur_col += len;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    int               w, h, k, c, r;
    logic             trunc;
    bmprle_pkg::res_t st;
    w = (cfg_w > MAX_W) ? MAX_W : cfg_w;
    h = (cfg_h > MAX_H) ? MAX_H : cfg_h;
    step_out.delete();
    if (!halted && ph == bmprle_pkg::PH_COUNT && cur_row >= h) halted = 1'b1;
    if (!halted) begin
      case (ph)
        bmprle_pkg::PH_COUNT: begin
          held_cnt = int'(b);
          ph = bmprle_pkg::PH_CODE;
        end
        bmprle_pkg::PH_CODE: begin
          if (held_cnt > 0) begin
            put_span(held_cnt, b, w, h);
            back_to_count(h);
          end else if (b == bmprle_pkg::ESC_EOL) begin
            cur_col = 0;
            cur_row = (cur_row + 1 < h) ? cur_row + 1 : h;
            back_to_count(h);
          end else if (b == bmprle_pkg::ESC_EOB) begin
            halted = 1'b1;
            ph = bmprle_pkg::PH_COUNT;
          end else if (b == bmprle_pkg::ESC_DELTA) begin
            ph = bmprle_pkg::PH_DX;
          end else if (cfg_mode == bmprle_pkg::MODE_RLE8) begin
            bytes_left = int'(b);
            nib_left = 0;
            pad_due = b[0];
            ph = bmprle_pkg::PH_DATA;
          end else begin
            nib_left = int'(b);
            bytes_left = (int'(b) + 1) / 2;
            pad_due = bytes_left[0];
            ph = bmprle_pkg::PH_DATA;
          end
        end
        bmprle_pkg::PH_DX: begin
          delta_col = int'(b);
          ph = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          c = cur_col + delta_col;
          r = cur_row + int'(b);
          cur_col = (c < w) ? c : w;
          cur_row = (r < h) ? r : h;
          back_to_count(h);
        end
        bmprle_pkg::PH_DATA: begin
          if (cfg_mode == bmprle_pkg::MODE_RLE8) begin
            put_span(1, b, w, h);
          end else begin
            k = (nib_left >= 2) ? 2 : nib_left;
            nib_left -= k;
            put_span(k, b, w, h);
          end
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) begin
            if (pad_due) ph = bmprle_pkg::PH_PAD;
            else back_to_count(h);
          end
        end
        bmprle_pkg::PH_PAD: begin
          pad_due = 1'b0;
          back_to_count(h);
        end
        default: back_to_count(h);
      endcase
    end
    if (fin) begin
      trunc = !halted && (ph == bmprle_pkg::PH_DX || ph == bmprle_pkg::PH_DY ||
                          ph == bmprle_pkg::PH_DATA);
      st = '0;
      st.kind = trunc ? bmprle_pkg::KIND_TRUNC : bmprle_pkg::KIND_DONE;
      step_out.push_back(st);
      clear_parse();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) predicted_spans.push_back(step_out[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    bmprle_pkg::res_t want;
    if (result_kind_o == bmprle_pkg::KIND_SPAN) spans_seen++;
    else status_seen++;
    if (predicted_spans.size() == 0) begin
      report_mismatch("result with none expected", 32'(result_kind_o), 32'd0);
      return;
    end
    want = predicted_spans.pop_front();
    if (result_kind_o !== want.kind)
      report_mismatch("kind", 32'(result_kind_o), 32'(want.kind));
    if (span_column_o !== want.column)
      report_mismatch("column", 32'(span_column_o), 32'(want.column));
    if (span_row_o !== want.row)
      report_mismatch("row", 32'(span_row_o), 32'(want.row));
    if (span_length_o !== want.length)
      report_mismatch("length", 32'(span_length_o), 32'(want.length));
    if (span_value_o !== want.value)
      report_mismatch("value", 32'(span_value_o), 32'(want.value));
    if (last_of_run_o !== want.last)
      report_mismatch("last", 32'(last_of_run_o), 32'(want.last));
  endtask

  // monitor: transactions sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid && !in_stall_o;
      if (out_valid_o && !out_stall) check_result();
      if (in_valid && !in_stall_o) begin
        bytes_in++;
        decode_byte(stream_byte, final_flag);
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!in_valid || in_taken) begin
      if (rst_ni && byte_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        next_item = byte_q.pop_front();
        in_valid <= 1'b1;
        stream_byte <= next_item.data;
        final_flag <= next_item.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, predicted_spans.size());
      $display("** bmp_rle_decoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bmprle_pkg::CFG_MODE:   cfg_mode = val[0];
      bmprle_pkg::CFG_WIDTH:  cfg_w = val & 32'h1FFF;
      bmprle_pkg::CFG_HEIGHT: cfg_h = val & 32'h1FFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained(input int extra);
    @(negedge clk_i);
    while (byte_q.size() > 0 || in_valid || predicted_spans.size() > 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    byte_q.push_back('{b, fin});
  endtask

  task automatic build_stream(input logic close);
    logic [7:0] s[$];
    int         ncmd, cmd, n, nb, i;
    logic       trunc;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(30, 5);
      repeat (n) s.push_back(8'($urandom));
    end else begin
      ncmd = $urandom_range(20, 4);
      trunc = close && ($urandom_range(99) < 15);
      for (i = 0; i < ncmd; i++) begin
        cmd = $urandom_range(99);
        if (cmd < 40) begin
          s.push_back(8'(($urandom_range(9) < 7) ? $urandom_range(20, 1)
                                                  : $urandom_range(255, 1)));
          s.push_back(8'($urandom));
        end else if (cmd < 55) begin
          s.push_back(8'd0);
          s.push_back(bmprle_pkg::ESC_EOL);
        end else if (cmd < 65) begin
          s.push_back(8'd0);
          s.push_back(bmprle_pkg::ESC_DELTA);
          s.push_back(8'(($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(255)));
          s.push_back(8'(($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(255)));
        end else if (cmd < 90) begin
          n = ($urandom_range(4) == 0) ? $urandom_range(255, 3) : $urandom_range(24, 3);
          nb = (cfg_mode == MODE_RLE4) ? (n + 1) / 2 : n;
          s.push_back(8'd0);
          s.push_back(8'(n));
          repeat (nb) s.push_back(8'($urandom));
          if (nb % 2 == 1) s.push_back(8'($urandom));
        end else if (cmd < 93) begin
          s.push_back(8'd0);
          s.push_back(bmprle_pkg::ESC_EOB);
        end else begin
          s.push_back(8'($urandom));
        end
      end
      if (trunc) begin
        s.push_back(8'd0);
        if ($urandom_range(1)) begin
          s.push_back(bmprle_pkg::ESC_DELTA);
          if ($urandom_range(1)) s.push_back(8'($urandom));
        end else begin
          n = $urandom_range(40, 3);
          nb = (cfg_mode == MODE_RLE4) ? (n + 1) / 2 : n;
          s.push_back(8'(n));
          repeat ($urandom_range(nb - 1)) s.push_back(8'($urandom));
        end
      end
    end
    foreach (s[j]) push_byte(s[j], close && (j == s.size() - 1));
  endtask

  initial begin
    int base;
    clear_parse();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration, RLE8 at full size
    push_byte(8'd5, 1'b0);   push_byte(8'hAA, 1'b0);
    push_byte(8'd0, 1'b0);   push_byte(bmprle_pkg::ESC_EOL, 1'b0);
    push_byte(8'd0, 1'b0);   push_byte(bmprle_pkg::ESC_DELTA, 1'b0);
    push_byte(8'hFF, 1'b0);  push_byte(8'd1, 1'b0);
    push_byte(8'd0, 1'b0);   push_byte(8'd3, 1'b0);
    push_byte(8'h11, 1'b0);  push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);  push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);  push_byte(8'h00, 1'b0);
    push_byte(8'd1, 1'b0);   push_byte(8'h7F, 1'b1);  // span and status on one byte
    push_byte(8'd0, 1'b0);   push_byte(bmprle_pkg::ESC_DELTA, 1'b0);
    push_byte(8'd3, 1'b1);                            // cut in delta
    push_byte(8'd0, 1'b0);   push_byte(bmprle_pkg::ESC_EOB, 1'b0);
    push_byte(8'h55, 1'b1);                           // ignored after end
    wait_drained(DRAIN_CYCLES);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 4) begin
        send_gap_pct = 77;
        recv_stall_pct = 38;
      end else if (seg == 8) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(bmprle_pkg::CFG_MODE, int'(seg_mode[seg]));
      // last segment keeps the sizes: mode flips inside an open stream
      if (seg != NUM_SEGS - 1) begin
        write_reg(bmprle_pkg::CFG_WIDTH, seg_w[seg]);
        write_reg(bmprle_pkg::CFG_HEIGHT, seg_h[seg]);
      end
      configs_used++;
      base = byte_q.size();
      while (byte_q.size() - base < ((seg_h[seg] == 0) ? 30 : SEG_BYTES)) build_stream(1'b1);
      if (seg == NUM_SEGS - 2) build_stream(1'b0);
      if (seg == 8) hold_arm = 1'b1;
      wait_drained(DRAIN_CYCLES);
    end

    wait_drained(20);
    $display("Covered %0d stream bytes over %0d configurations in RLE8 and RLE4;",
             bytes_in, configs_used);
    $display("checked %0d spans and %0d end-of-stream results, incl. size extremes,",
             spans_seen, status_seen);
    $display("truncated streams, a mid-stream mode change and a long output hold-off.");
    if (mismatches == 0) begin
      $display("** bmp_rle_decoder: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** bmp_rle_decoder: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/bmprle_pkg.sv
sv/bmprle_core.sv
sv/bmp_rle_decoder.sv
tb/tb_bmp_rle_decoder.sv
